// ===== hdl/ffpc_pkg.sv =====
// shared types, constants and float helpers for the flat-field pixel correction
// no dependencies; used by every other file of the block except ffpc_delay
package ffpc_pkg;

  // canonical quiet nan
  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  // working mantissa width for rounding, leading one at the top bit
  localparam int unsigned MAN_W = 50;

  // reciprocal divider: quotient bits, bits per stage, stage count
  localparam int unsigned DIV_BITS  = 28;
  localparam int unsigned DIV_STEP  = 4;
  localparam int unsigned DIV_STGS  = DIV_BITS / DIV_STEP;

  // unit latencies in enabled cycles
  localparam int unsigned RECIP_LAT = DIV_STGS + 2;
  localparam int unsigned FMUL_LAT  = 4;

  typedef logic signed [11:0] exp_t;
  typedef logic [MAN_W-1:0]   man_t;

  // leading zero count of a 24-bit mantissa
  function automatic logic [4:0] lzc24(input logic [23:0] man);
    logic [4:0] lz;
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (man[i]) begin
        lz = 5'(23 - i);
      end
    end
    return lz;
  endfunction

  // round to nearest even and pack, subnormal results kept, overflow to inf
  function automatic logic [31:0] fp_round(input logic sgn, input exp_t ex,
                                           input man_t man, input logic stk);
    logic [5:0]  sh;
    man_t        sm;
    logic        lost;
    logic [7:0]  ef;
    logic [30:0] pk;
    logic        inc;
    if (ex >= 12'sd255) begin
      return {sgn, 8'hFF, 23'h0};
    end
    if (ex <= 12'sd0) begin
      sh = (ex < -12'sd49) ? 6'd51 : 6'(12'sd1 - ex);
      ef = 8'd0;
    end else begin
      sh = 6'd0;
      ef = ex[7:0];
    end
    sm   = man >> sh;
    lost = |(man & ~({MAN_W{1'b1}} << sh));
    inc  = sm[MAN_W-25] & ((|sm[MAN_W-26:0]) | lost | stk | sm[MAN_W-24]);
    pk   = {ef, sm[MAN_W-2:MAN_W-24]} + 31'(inc);
    return {sgn, pk};
  endfunction

endpackage

// ===== hdl/ffpc_delay.sv =====
// enabled delay line that keeps side data aligned with the arithmetic units
// uses no package
module ffpc_delay #(
  parameter int unsigned W = 16,
  parameter int unsigned D = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] pipe_r [D];

  // shift by one place each enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= din;
      for (int i = 1; i < D; i++) begin
        pipe_r[i] <= pipe_r[i-1];
      end
    end
  end

  assign dout = pipe_r[D-1];

endmodule

// ===== hdl/ffpc_fmul.sv =====
// four-stage single precision multiplier, round to nearest even, subnormals kept
// depends on ffpc_pkg (fp_round, lzc24, QNAN)
module ffpc_fmul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_vld,
  output logic [31:0] y
);

  // stage 1: classify, leading zero counts
  logic        vld1_r, vld2_r, vld3_r, vld4_r;
  logic        spc1_r, spc2_r, spc3_r;
  logic [31:0] spv1_r, spv2_r, spv3_r;
  logic        sgn1_r, sgn2_r, sgn3_r;
  logic [23:0] ma1_r, mb1_r;
  logic [4:0]  lza1_r, lzb1_r;
  ffpc_pkg::exp_t ea1_r, eb1_r;
  logic [23:0] na2_r, nb2_r;
  ffpc_pkg::exp_t e2_r, e3_r;
  logic [47:0] p3_r;
  logic [31:0] y4_r;
  logic [31:0] rnd_y;

  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
  logic        spc_nxt;
  logic [31:0] spv_nxt;
  logic [23:0] ma_nxt, mb_nxt;
  logic [4:0]  lza_nxt, lzb_nxt;
  logic [7:0]  xa, xb;

  always_comb begin
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'h0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'h0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'h0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'h0);
    a_zero = (a[30:0] == 31'h0);
    b_zero = (b[30:0] == 31'h0);
    sgn    = a[31] ^ b[31];
    spc_nxt = 1'b1;
    if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
      spv_nxt = ffpc_pkg::QNAN;
    end else if (a_inf || b_inf) begin
      spv_nxt = {sgn, 8'hFF, 23'h0};
    end else if (a_zero || b_zero) begin
      spv_nxt = {sgn, 31'h0};
    end else begin
      spv_nxt = 32'h0;
      spc_nxt = 1'b0;
    end
    ma_nxt  = {a[30:23] != 8'h0, a[22:0]};
    mb_nxt  = {b[30:23] != 8'h0, b[22:0]};
    lza_nxt = ffpc_pkg::lzc24(ma_nxt);
    lzb_nxt = ffpc_pkg::lzc24(mb_nxt);
    xa      = (a[30:23] == 8'h0) ? 8'd1 : a[30:23];
    xb      = (b[30:23] == 8'h0) ? 8'd1 : b[30:23];
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      spc1_r <= spc_nxt;
      spv1_r <= spv_nxt;
      sgn1_r <= sgn;
      ma1_r  <= ma_nxt;
      mb1_r  <= mb_nxt;
      lza1_r <= lza_nxt;
      lzb1_r <= lzb_nxt;
      ea1_r  <= $signed({4'b0, xa}) - $signed({7'b0, lza_nxt});
      eb1_r  <= $signed({4'b0, xb}) - $signed({7'b0, lzb_nxt});
      // stage 2: normalize
      spc2_r <= spc1_r;
      spv2_r <= spv1_r;
      sgn2_r <= sgn1_r;
      na2_r  <= ma1_r << lza1_r;
      nb2_r  <= mb1_r << lzb1_r;
      e2_r   <= ea1_r + eb1_r;
      // stage 3: mantissa product
      spc3_r <= spc2_r;
      spv3_r <= spv2_r;
      sgn3_r <= sgn2_r;
      p3_r   <= na2_r * nb2_r;
      e3_r   <= e2_r;
      // stage 4: round and pack
      y4_r   <= spc3_r ? spv3_r : rnd_y;
    end
  end

  always_comb begin
    if (p3_r[47]) begin
      rnd_y = ffpc_pkg::fp_round(sgn3_r, e3_r - 12'sd126, {p3_r, 2'b0}, 1'b0);
    end else begin
      rnd_y = ffpc_pkg::fp_round(sgn3_r, e3_r - 12'sd127, {p3_r[46:0], 3'b0}, 1'b0);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  assign out_vld = vld4_r;
  assign y       = y4_r;

endmodule

// ===== hdl/ffpc_recip.sv =====
// pipelined reciprocal of the flat value: unpack, radix-2 restoring divide
// four quotient bits per stage, then round; depends on ffpc_pkg
module ffpc_recip (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [31:0] flat,
  output logic        out_vld,
  output logic [31:0] recip,
  output logic        bad
);

  localparam int unsigned NS = ffpc_pkg::DIV_STGS;

  logic [23:0]    m_r   [NS+1];
  ffpc_pkg::exp_t e_r   [NS+1];
  logic [24:0]    rem_r [NS+1];
  logic [27:0]    quo_r [NS+1];
  logic           bin_r [NS+1];
  logic           vld_r [NS+1];
  logic [31:0]    rcp_r;
  logic           rbad_r;
  logic           rvld_r;

  // unpack; subnormal flats below 2^-128 overflow and are flagged here
  logic [23:0]    m0;
  ffpc_pkg::exp_t e0;
  logic           bin0;
  always_comb begin
    bin0 = flat[31] || (flat[30:0] == 31'h0) || (flat[30:23] == 8'hFF) ||
           ((flat[30:23] == 8'h0) && (flat[22:21] == 2'b00));
    if (flat[30:23] != 8'h0) begin
      m0 = {1'b1, flat[22:0]};
      e0 = $signed({4'b0, flat[30:23]});
    end else if (flat[22]) begin
      m0 = {flat[22:0], 1'b0};
      e0 = 12'sd0;
    end else begin
      m0 = {flat[21:0], 2'b0};
      e0 = -12'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]   <= m0;
      e_r[0]   <= e0;
      bin_r[0] <= bin0;
      rem_r[0] <= 25'h080_0000;
      quo_r[0] <= 28'h0;
    end
  end

  // divide stages
  for (genvar k = 1; k <= NS; k++) begin : g_div
    logic [24:0] rem_nxt;
    logic [27:0] quo_nxt;
    always_comb begin
      logic qb;
      rem_nxt = rem_r[k-1];
      quo_nxt = quo_r[k-1];
      for (int j = 0; j < ffpc_pkg::DIV_STEP; j++) begin
        qb = (rem_nxt >= {1'b0, m_r[k-1]});
        if (qb) begin
          rem_nxt = rem_nxt - {1'b0, m_r[k-1]};
        end
        quo_nxt = {quo_nxt[26:0], qb};
        rem_nxt = {rem_nxt[23:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[k]   <= m_r[k-1];
        e_r[k]   <= e_r[k-1];
        bin_r[k] <= bin_r[k-1];
        rem_r[k] <= rem_nxt;
        quo_r[k] <= quo_nxt;
      end
    end
  end

  // round the quotient to single
  logic [31:0] rcp_nxt;
  always_comb begin
    if (quo_r[NS][27]) begin
      rcp_nxt = ffpc_pkg::fp_round(1'b0, 12'sd254 - e_r[NS],
                                   {1'b1, {(ffpc_pkg::MAN_W-1){1'b0}}}, 1'b0);
    end else begin
      rcp_nxt = ffpc_pkg::fp_round(1'b0, 12'sd253 - e_r[NS],
                                   {quo_r[NS][26:0], 23'h0}, rem_r[NS] != 25'h0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rcp_r  <= rcp_nxt;
      rbad_r <= bin_r[NS] || (rcp_nxt[30:23] == 8'hFF);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS; i++) begin
        vld_r[i] <= 1'b0;
      end
      rvld_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i <= NS; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      rvld_r <= vld_r[NS];
    end
  end

  assign out_vld = rvld_r;
  assign recip   = rcp_r;
  assign bad     = rbad_r;

endmodule

// ===== hdl/flat_field_pixel_correct_unit.sv =====
// flat-field pixel correction: value * (1/flat), variance * (1/flat)^2
// a beat passes the reciprocal, then the r * r and variance multipliers in series, then the output register
// throughput one beat per cycle while in_stall is low; in_stall rises only while the output skid slot is full
// synchronous active-low reset clears valids and bad_flat_bits; data registers are not reset
// depends on ffpc_pkg, ffpc_delay, ffpc_fmul, ffpc_recip
module flat_field_pixel_correct_unit #(
  parameter int unsigned MASK_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_pixel_value,
  input  logic [31:0] in_pixel_variance,
  input  logic [15:0] in_pixel_mask,
  input  logic [31:0] in_flat_value,
  input  logic [15:0] in_flat_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value,
  output logic [31:0] out_variance,
  output logic [15:0] out_mask,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_bad_flat_bits
);

  localparam logic [15:0] MaskKeep =
    (MASK_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << MASK_WIDTH) - 32'd1);
  localparam int unsigned RL = ffpc_pkg::RECIP_LAT;
  localparam int unsigned ML = ffpc_pkg::FMUL_LAT;

  logic [15:0] bad_flat_bits_r;
  logic        skid_v_r, out_valid_r;
  logic [31:0] skid_val_r, skid_var_r, out_val_r, out_var_r;
  logic [15:0] skid_msk_r, out_msk_r;
  logic        en;

  // pipeline runs whenever the skid slot is free
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_flat_bits_r <= 16'h0;
    end else if (cfg_valid) begin
      bad_flat_bits_r <= cfg_bad_flat_bits;
    end
  end

  // reciprocal of the flat
  logic        r_vld, r_bad;
  logic [31:0] r_val;
  ffpc_recip u_recip (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid && en),
    .flat   (in_flat_value),
    .out_vld(r_vld),
    .recip  (r_val),
    .bad    (r_bad)
  );

  // side data aligned to the reciprocal and multiplier results
  logic [31:0] pv_d, pvar_d;
  logic [15:0] pmask_d;
  logic        fbad_d, bad_d;
  ffpc_delay #(.W(32), .D(RL)) u_dly_pv (
    .clk(clk), .en(en), .din(in_pixel_value), .dout(pv_d));
  ffpc_delay #(.W(32), .D(RL + ML)) u_dly_pvar (
    .clk(clk), .en(en), .din(in_pixel_variance), .dout(pvar_d));
  ffpc_delay #(.W(16), .D(RL + 2 * ML)) u_dly_mask (
    .clk(clk), .en(en), .din(in_pixel_mask & MaskKeep), .dout(pmask_d));
  ffpc_delay #(.W(1), .D(RL)) u_dly_fbad (
    .clk(clk), .en(en), .din((in_flat_mask & MaskKeep) != 16'h0), .dout(fbad_d));
  ffpc_delay #(.W(1), .D(2 * ML)) u_dly_bad (
    .clk(clk), .en(en), .din(r_bad || fbad_d), .dout(bad_d));

  // value * r and r * r
  logic        v_vld, r2_vld, w_vld;
  logic [31:0] v_res, r2_res, w_res, v_d;
  ffpc_fmul u_mul_v (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(r_vld),
    .a(pv_d), .b(r_val), .out_vld(v_vld), .y(v_res));
  ffpc_fmul u_mul_r2 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(r_vld),
    .a(r_val), .b(r_val), .out_vld(r2_vld), .y(r2_res));
  ffpc_delay #(.W(32), .D(ML)) u_dly_v (
    .clk(clk), .en(en), .din(v_res), .dout(v_d));

  // variance * r^2; v_vld tracks r2_vld and is only ANDed into this multiplier's valid
  ffpc_fmul u_mul_w (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(r2_vld && v_vld),
    .a(pvar_d), .b(r2_res), .out_vld(w_vld), .y(w_res));

  // final select
  logic [31:0] fin_val, fin_var;
  logic [15:0] fin_msk;
  always_comb begin
    if (bad_d) begin
      fin_val = ffpc_pkg::QNAN;
      fin_var = ffpc_pkg::QNAN;
      fin_msk = pmask_d | (bad_flat_bits_r & MaskKeep);
    end else begin
      fin_val = v_d;
      fin_var = w_res;
      fin_msk = pmask_d;
    end
  end

  // output register with skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end else begin
        out_valid_r <= w_vld;
      end
    end else if (w_vld && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_v_r) begin
        out_val_r <= skid_val_r;
        out_var_r <= skid_var_r;
        out_msk_r <= skid_msk_r;
      end else begin
        out_val_r <= fin_val;
        out_var_r <= fin_var;
        out_msk_r <= fin_msk;
      end
    end else if (en) begin
      skid_val_r <= fin_val;
      skid_var_r <= fin_var;
      skid_msk_r <= fin_msk;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_val_r;
  assign out_variance = out_var_r;
  assign out_mask     = out_msk_r;

endmodule

// ===== verif/tb_flat_field_pixel_correct_unit.sv =====
// testbench for flat_field_pixel_correct_unit: bit-exact flat-field correction checks
// depends on ffpc_pkg (quiet nan constant) and the block's rtl; self-checking, no files read
module tb_flat_field_pixel_correct_unit;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam logic [31:0] POS_INF        = 32'h7F80_0000;

  typedef struct {
    logic [31:0] value;
    logic [31:0] variance;
    logic [15:0] mask;
  } px_out_t;

  // ---------------------------------------------------------------------------
  // exact single-precision arithmetic, round to nearest even, subnormals kept

  // round n * 2^e2 (plus a sticky remainder) to a single
  function automatic logic [31:0] round_single(input logic s, input logic [127:0] n,
                                               input int e2, input logic stk);
    int          p;
    int          sh;
    int          ex;
    int          biased;
    logic [127:0] kept;
    logic [127:0] low;
    logic        half;
    logic        rest;
    logic        inc;
    p = 0;
    for (int i = 0; i < 128; i++) begin
      if (n[i]) begin
        p = i;
      end
    end
    if (n == 0) begin
      return {s, 31'h0};
    end
    sh = p - 23;
    if (sh < -149 - e2) begin
      sh = -149 - e2;
    end
    // far below half the smallest subnormal
    if (sh > p + 1) begin
      return {s, 31'h0};
    end
    if (sh > 0) begin
      kept = n >> sh;
      half = n[sh-1];
      low  = n & ((128'd1 << (sh - 1)) - 1);
      rest = (low != 0) || stk;
      inc  = half && (rest || kept[0]);
    end else begin
      kept = n << (-sh);
      inc  = 1'b0;
    end
    kept = kept + 128'(inc);
    ex   = e2 + sh;
    if (kept[24]) begin
      kept = kept >> 1;
      ex   = ex + 1;
    end
    biased = kept[23] ? ex + 150 : 0;
    if (biased >= 255) begin
      return {s, POS_INF[30:0]};
    end
    return {s, biased[7:0], kept[22:0]};
  endfunction

  // split a finite nonzero single into integer mantissa and power of two
  function automatic void split_single(input logic [31:0] a, output logic [23:0] m,
                                       output int e);
    if (a[30:23] == 8'd0) begin
      m = {1'b0, a[22:0]};
      e = -149;
    end else begin
      m = {1'b1, a[22:0]};
      e = int'(a[30:23]) - 150;
    end
  endfunction

  function automatic logic is_nan(input logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] != 0;
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    logic        a_inf;
    logic        b_inf;
    logic        a_zero;
    logic        b_zero;
    logic [23:0] ma;
    logic [23:0] mb;
    int          ea;
    int          eb;
    s      = a[31] ^ b[31];
    a_inf  = a[30:0] == POS_INF[30:0];
    b_inf  = b[30:0] == POS_INF[30:0];
    a_zero = a[30:0] == 0;
    b_zero = b[30:0] == 0;
    if (is_nan(a) || is_nan(b) || (a_inf && b_zero) || (b_inf && a_zero)) begin
      return ffpc_pkg::QNAN;
    end
    if (a_inf || b_inf) begin
      return {s, POS_INF[30:0]};
    end
    if (a_zero || b_zero) begin
      return {s, 31'h0};
    end
    split_single(a, ma, ea);
    split_single(b, mb, eb);
    return round_single(s, 128'(ma) * 128'(mb), ea + eb, 1'b0);
  endfunction

  // reciprocal of a positive finite nonzero single
  function automatic logic [31:0] fp_recip(input logic [31:0] a);
    logic [23:0]  m;
    int           e;
    logic [127:0] num;
    split_single(a, m, e);
    num = 128'd1 << 100;
    return round_single(1'b0, num / m, -100 - e, (num % m) != 0);
  endfunction

  // ---------------------------------------------------------------------------
  // scoreboard: predicts each corrected pixel and checks it in order
  class pixel_correct_board;
    px_out_t     want_q[$];
    logic [15:0] bad_bits;
    int          fails;
    int          checked;
    int          bad_seen;

    function void set_bad_bits(logic [15:0] v);
      bad_bits = v;
    endfunction

    function void note_pixel(logic [31:0] pv, logic [31:0] pvar, logic [15:0] pmask,
                             logic [31:0] fv, logic [15:0] fmask);
      px_out_t     w;
      logic        bad;
      logic [31:0] r;
      bad = 1'b0;
      r   = 32'h0;
      if (fv[31] || fv[30:0] == 0 || fv[30:23] == 8'hFF) begin
        bad = 1'b1;
      end else begin
        r = fp_recip(fv);
        if (r[30:23] == 8'hFF || r[31] || r[30:0] == 0) begin
          bad = 1'b1;
        end
      end
      if (fmask != 0) begin
        bad = 1'b1;
      end
      if (bad) begin
        w.value    = ffpc_pkg::QNAN;
        w.variance = ffpc_pkg::QNAN;
        w.mask     = pmask | bad_bits;
        bad_seen++;
      end else begin
        w.value    = fp_mul(pv, r);
        w.variance = fp_mul(pvar, fp_mul(r, r));
        w.mask     = pmask;
      end
      want_q.push_back(w);
    endfunction

    function void check_pixel(logic [31:0] v, logic [31:0] var_o, logic [15:0] m);
      px_out_t w;
      if (want_q.size() == 0) begin
        $error("unexpected result beat: value %h variance %h mask %h", v, var_o, m);
        fails++;
        return;
      end
      w = want_q.pop_front();
      checked++;
      if (v !== w.value) begin
        $error("out_value: expected %h actual %h", w.value, v);
        fails++;
      end
      if (var_o !== w.variance) begin
        $error("out_variance: expected %h actual %h", w.variance, var_o);
        fails++;
      end
      if (m !== w.mask) begin
        $error("out_mask: expected %h actual %h", w.mask, m);
        fails++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_pixel_value = '0;
  logic [31:0] in_pixel_variance = '0;
  logic [15:0] in_pixel_mask = '0;
  logic [31:0] in_flat_value = '0;
  logic [15:0] in_flat_mask = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_value;
  logic [31:0] out_variance;
  logic [15:0] out_mask;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_bad_flat_bits = '0;

  pixel_correct_board board = new();
  logic no_idle = 1'b0;
  int   idle_cycles = 0;

  always #2 clk = ~clk;

  flat_field_pixel_correct_unit #(.MASK_WIDTH(16)) u_dut (.*);

  // result side: random stall, check each accepted beat
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_pixel(out_value, out_variance, out_mask);
    end
    out_stall <= rst_n && !no_idle && ($urandom_range(99) < 24);
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout with %0d results outstanding", board.want_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_bad_bits(input logic [15:0] v);
    cfg_valid         <= 1'b1;
    cfg_bad_flat_bits <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.set_bad_bits(v);
  endtask

  // one input beat, with random idle cycles ahead of it
  task automatic send_pixel(input logic [31:0] pv, input logic [31:0] pvar,
                            input logic [15:0] pmask, input logic [31:0] fv,
                            input logic [15:0] fmask);
    while (!no_idle && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_pixel_value    <= pv;
    in_pixel_variance <= pvar;
    in_pixel_mask     <= pmask;
    in_flat_value     <= fv;
    in_flat_mask      <= fmask;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_pixel(pv, pvar, pmask, fv, fmask);
  endtask

  // wait for every expected result, then let the pipeline settle
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.want_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_flat();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 60) return {1'b0, 8'($urandom_range(150, 104)), 23'($urandom())};
    if (k < 70) return $urandom();
    if (k < 76) return {1'b0, 8'd0, 23'($urandom())};
    if (k < 80) return {1'b0, 8'($urandom_range(254, 240)), 23'($urandom())};
    if (k < 85) return {1'b1, 31'($urandom())};
    if (k < 90) return {1'($urandom_range(1)), 31'h0};
    if (k < 95) return {1'($urandom_range(1)), 8'hFF, 23'h0};
    return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(32'h7F_FFFF, 1))};
  endfunction

  function automatic logic [31:0] rand_pixel();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 50) return $urandom();
    if (k < 85) return {1'($urandom_range(1)), 8'($urandom_range(160, 90)), 23'($urandom())};
    if (k < 90) return {1'($urandom_range(1)), 8'd0, 23'($urandom())};
    if (k < 95) return {1'($urandom_range(1)), 8'hFF, 23'h0};
    return {1'($urandom_range(1)), 31'h0};
  endfunction

  logic [15:0] bad_bits_set[4] = '{16'h0000, 16'h8001, 16'hFFFF, 16'h0000};

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pixels, all bad-flat bits set
    write_bad_bits(16'hFFFF);
    send_pixel(32'h4040_0000, 32'h4000_0000, 16'h0001, 32'h3F80_0000, 16'h0000);  // flat one
    send_pixel(32'h4040_0000, 32'h4000_0000, 16'h0000, 32'h4000_0000, 16'h0000);
    send_pixel(32'hC0A0_0000, 32'h3F80_0000, 16'h1234, 32'h3F00_0000, 16'h0000);
    send_pixel(32'h3F80_0000, 32'h3F80_0000, 16'h0000, 32'h4040_0000, 16'h0000);  // inexact 1/3
    send_pixel(32'h3F80_0000, 32'h3F80_0000, 16'h0002, 32'h0000_0000, 16'h0000);  // +0 flat
    send_pixel(32'h3F80_0000, 32'h3F80_0000, 16'h0000, 32'h8000_0000, 16'h0000);  // -0 flat
    send_pixel(32'h3F80_0000, 32'h3F80_0000, 16'h0000, 32'h7F80_0000, 16'h0000);  // +inf flat
    send_pixel(32'h3F80_0000, 32'h3F80_0000, 16'h0000, 32'hFF80_0000, 16'h0000);  // -inf flat
    send_pixel(32'h3F80_0000, 32'h3F80_0000, 16'h0000, 32'h7FC0_0000, 16'h0000);  // quiet nan
    send_pixel(32'h3F80_0000, 32'h3F80_0000, 16'h0000, 32'hFF80_0001, 16'h0000);  // signaling nan
    send_pixel(32'h3F80_0000, 32'h3F80_0000, 16'h0000, 32'hBF80_0000, 16'h0000);  // negative
    send_pixel(32'h3F80_0000, 32'h3F80_0000, 16'h0000, 32'h0000_0001, 16'h0000);  // recip overflow
    send_pixel(32'h3F80_0000, 32'h3F80_0000, 16'h0000, 32'h0020_0000, 16'h0000);  // 2^-128
    send_pixel(32'h3F80_0000, 32'h3F80_0000, 16'h0000, 32'h0040_0000, 16'h0000);  // r2 to inf
    send_pixel(32'h7F7F_FFFF, 32'h7F80_0000, 16'h0000, 32'h7F7F_FFFF, 16'h0000);  // r subnormal
    send_pixel(32'h0000_0001, 32'h3F80_0000, 16'h0000, 32'h4000_0000, 16'h0000);  // subnormal pixel
    send_pixel(32'h3F80_0000, 32'h3F80_0000, 16'hFFFF, 32'h3F80_0000, 16'h8000);  // flat masked
    send_pixel(32'h7FC0_0001, 32'hFFFF_FFFF, 16'h0000, 32'h3F80_0000, 16'h0000);  // nan pixel
    send_pixel(32'hFF80_0000, 32'h8000_0000, 16'h0000, 32'h3F00_0000, 16'h0000);  // inf pixel
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'h7F7F_FFFF, 16'hFFFF);
    send_pixel(32'h0000_0000, 32'h0000_0000, 16'h0000, 32'h0080_0000, 16'h0000);
    drain();

    // random phases under several bad-flat settings; third phase runs without idling
    for (int ph = 0; ph < 5; ph++) begin
      write_bad_bits(ph == 4 ? 16'($urandom()) : bad_bits_set[ph]);
      no_idle = (ph == 2);
      for (int i = 0; i < 260; i++) begin
        send_pixel(rand_pixel(), rand_pixel(), 16'($urandom()), rand_flat(),
                   ($urandom_range(99) < 80) ? 16'h0000 : 16'($urandom()));
      end
      drain();
      no_idle = 1'b0;
    end

    $display("checked %0d corrected pixels, %0d of them with an unusable flat",
             board.checked, board.bad_seen);
    $display("five bad-flat settings including all-zero and all-one, one phase without idling");
    if (board.fails == 0 && board.want_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== flat_field_pixel_correct_unit.f =====
hdl/ffpc_pkg.sv
hdl/ffpc_delay.sv
hdl/ffpc_fmul.sv
hdl/ffpc_recip.sv
hdl/flat_field_pixel_correct_unit.sv
verif/tb_flat_field_pixel_correct_unit.sv
